@@ src/tbped_pkg.sv @@
// Shared types and constants of the two-button press event detector.
package tbped_pkg;

  localparam int MAX_EVENTS  = 4;
  localparam int EV_IDX_W    = $clog2(MAX_EVENTS);
  localparam int EV_CNT_W    = $clog2(MAX_EVENTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int HOLD_W      = 8;
  localparam int CFG_IDX_W   = 1;

  localparam logic [HOLD_W-1:0] LONG_HOLD_RST  = 8'd3;
  localparam logic [HOLD_W-1:0] COMBO_HOLD_RST = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_HOLD  = 1'b0,
    CFG_COMBO_HOLD = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    EV_SET_DOWN   = 4'd0,
    EV_SET_UP     = 4'd1,
    EV_SET_PRESS  = 4'd2,
    EV_SET_LONG   = 4'd3,
    EV_MODE_DOWN  = 4'd4,
    EV_MODE_UP    = 4'd5,
    EV_MODE_PRESS = 4'd6,
    EV_MODE_LONG  = 4'd7,
    EV_BOTH_PRESS = 4'd8,
    EV_BOTH_LONG  = 4'd9
  } event_code_t;

  // Events of one scan, oldest in slot 0.
  typedef struct packed {
    event_code_t [MAX_EVENTS-1:0] codes;
    logic [EV_CNT_W-1:0]          count;
  } evt_list_t;

  // Hand-off between the front end and the event queue.
  typedef struct packed {
    logic      valid;
    evt_list_t list;
  } evt_push_t;

endpackage

@@ src/tbped_if.sv @@
// Scan and event channel interfaces of the two-button press event detector.
interface tbped_in_if;
  logic                           valid;
  logic                           ready;
  logic                           set_level;
  logic                           set_confirm;
  logic                           mode_level;
  logic                           mode_confirm;
  logic [tbped_pkg::TIME_W-1:0]   now_seconds;

  modport source (output valid, set_level, set_confirm, mode_level, mode_confirm,
                  now_seconds, input ready);
  modport sink   (input valid, set_level, set_confirm, mode_level, mode_confirm,
                  now_seconds, output ready);
endinterface

interface tbped_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_code;
  logic       last_event;

  modport source (output valid, event_code, last_event, input ready);
  modport sink   (input valid, event_code, last_event, output ready);
endinterface

@@ src/tbped_front.sv @@
// Front end: classify one scan into its list of button events and update button state.
module tbped_front #(
  parameter int REPEAT_DIVIDE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          scan_valid,
  output logic                          scan_ready,
  input  logic                          set_level,
  input  logic                          set_confirm,
  input  logic                          mode_level,
  input  logic                          mode_confirm,
  input  logic [tbped_pkg::TIME_W-1:0]  now_seconds,
  input  logic [tbped_pkg::HOLD_W-1:0]  long_hold,
  input  logic [tbped_pkg::HOLD_W-1:0]  combo_hold,
  output tbped_pkg::evt_push_t          push,
  input  logic                          push_ready
);

  localparam int CW = (REPEAT_DIVIDE > 1) ? $clog2(REPEAT_DIVIDE) : 1;
  localparam logic [CW-1:0] RC_TOP = CW'(REPEAT_DIVIDE - 1);
  localparam int TW = tbped_pkg::TIME_W;
  localparam int PAD = TW - tbped_pkg::HOLD_W;

  logic          set_held_r, set_held_nxt;
  logic          mode_held_r, mode_held_nxt;
  logic [TW-1:0] set_stamp_r, set_stamp_nxt;
  logic [TW-1:0] mode_stamp_r, mode_stamp_nxt;
  logic [CW-1:0] rc_r, rc_nxt;

  logic          take;
  logic [TW-1:0] set_diff, mode_diff, long_ext, combo_ext;
  logic          set_down, set_rep, set_rel, set_short, set_long_ev;
  logic          mode_down, mode_rep, mode_rel, mode_short, mode_long_ev;
  logic          set_combo_ok, mode_combo_ok, combo_rep, combo_ev;
  logic [CW-1:0] rc_a, rc_b, rc_c;
  logic [1:0]    n_set, n_mode;
  logic          n_combo;
  logic [3:0]    n_total;
  tbped_pkg::event_code_t [2:0] set_codes, mode_codes;
  tbped_pkg::evt_list_t list;

  function automatic logic [CW-1:0] tick(input logic [CW-1:0] rc);
    tick = (rc == RC_TOP) ? '0 : rc + 1'b1;
  endfunction

  assign scan_ready = push_ready;
  assign take       = scan_valid && scan_ready;

  assign long_ext  = {{PAD{1'b0}}, long_hold};
  assign combo_ext = {{PAD{1'b0}}, combo_hold};
  assign set_diff  = now_seconds - set_stamp_r;
  assign mode_diff = now_seconds - mode_stamp_r;

  always_comb begin
    // set button first
    set_down  = set_level && !set_held_r && set_confirm;
    set_rep   = set_level && set_held_r && (set_diff >= long_ext);
    set_rel   = !set_level && set_held_r;
    set_short = set_rel && (set_diff < long_ext);
    set_held_nxt = set_down || (set_held_r && set_level);

    // mode button sees the set flag as it stands after the set step
    mode_down  = mode_level && !mode_held_r && mode_confirm;
    mode_rep   = mode_level && mode_held_r && (mode_diff >= long_ext);
    mode_rel   = !mode_level && mode_held_r;
    mode_short = mode_rel && (mode_diff < long_ext);
    mode_held_nxt = mode_down || (mode_held_r && mode_level);

    // a fresh press has zero elapsed time
    set_combo_ok  = set_down  ? (combo_hold == '0) : (set_diff  >= combo_ext);
    mode_combo_ok = mode_down ? (combo_hold == '0) : (mode_diff >= combo_ext);
    combo_rep = set_level && set_held_nxt && mode_level && mode_held_nxt &&
                set_combo_ok && mode_combo_ok;

    // shared repeat counter, advanced in scan order
    rc_a = set_down ? '0 : (set_rep ? tick(rc_r) : rc_r);
    set_long_ev = set_rep && (rc_a == '0);
    rc_b = mode_down ? '0 : (mode_rep ? tick(rc_a) : rc_a);
    mode_long_ev = mode_rep && (rc_b == '0);
    rc_c = combo_rep ? tick(rc_b) : rc_b;
    combo_ev = combo_rep && (rc_c == '0);
    rc_nxt = rc_c;

    set_codes[0] = set_down ? tbped_pkg::EV_SET_DOWN :
                   (set_rep ? tbped_pkg::EV_SET_LONG : tbped_pkg::EV_SET_UP);
    set_codes[1] = tbped_pkg::EV_SET_PRESS;
    set_codes[2] = tbped_pkg::EV_BOTH_PRESS;
    if (set_down || set_long_ev) begin
      n_set = 2'd1;
    end else if (set_rel) begin
      n_set = set_short ? (mode_held_r ? 2'd3 : 2'd2) : 2'd1;
    end else begin
      n_set = 2'd0;
    end

    mode_codes[0] = mode_down ? tbped_pkg::EV_MODE_DOWN :
                    (mode_rep ? tbped_pkg::EV_MODE_LONG : tbped_pkg::EV_MODE_UP);
    mode_codes[1] = tbped_pkg::EV_MODE_PRESS;
    mode_codes[2] = tbped_pkg::EV_BOTH_PRESS;
    if (mode_down || mode_long_ev) begin
      n_mode = 2'd1;
    end else if (mode_rel) begin
      n_mode = mode_short ? (set_held_nxt ? 2'd3 : 2'd2) : 2'd1;
    end else begin
      n_mode = 2'd0;
    end

    n_combo = combo_ev;
    n_total = {2'b00, n_set} + {2'b00, n_mode} + {3'b000, n_combo};

    // merge the three lists, dropping anything past the last slot
    for (int k = 0; k < tbped_pkg::MAX_EVENTS; k++) begin
      logic [2:0] kk;
      logic [2:0] j;
      kk = 3'(k);
      j  = kk - {1'b0, n_set};
      if (kk < {1'b0, n_set}) begin
        list.codes[k] = set_codes[kk[1:0]];
      end else if (j < {1'b0, n_mode}) begin
        list.codes[k] = mode_codes[j[1:0]];
      end else begin
        list.codes[k] = tbped_pkg::EV_BOTH_LONG;
      end
    end
    list.count = (n_total > 4'(tbped_pkg::MAX_EVENTS)) ?
                 tbped_pkg::EV_CNT_W'(tbped_pkg::MAX_EVENTS) :
                 tbped_pkg::EV_CNT_W'(n_total);

    set_stamp_nxt  = set_down  ? now_seconds : set_stamp_r;
    mode_stamp_nxt = mode_down ? now_seconds : mode_stamp_r;
  end

  assign push.valid = take && (list.count != '0);
  assign push.list  = list;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_held_r   <= 1'b0;
      mode_held_r  <= 1'b0;
      set_stamp_r  <= '0;
      mode_stamp_r <= '0;
      rc_r         <= '0;
    end else if (take) begin
      set_held_r   <= set_held_nxt;
      mode_held_r  <= mode_held_nxt;
      set_stamp_r  <= set_stamp_nxt;
      mode_stamp_r <= mode_stamp_nxt;
      rc_r         <= rc_nxt;
    end
  end

  a_rc_range: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= RC_TOP)
    else $error("repeat counter out of range");

  a_down_latches: assert property (@(posedge clk) disable iff (!rst_n)
    take && set_down |=> set_held_r)
    else $error("set press not recorded");

endmodule

@@ src/tbped_queue.sv @@
// Short queue of per-scan event lists between front end and back end.
module tbped_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tbped_pkg::evt_push_t  push,
  output logic                  push_ready,
  output logic                  pop_valid,
  output tbped_pkg::evt_list_t  pop_list,
  input  logic                  pop
);

  localparam int DEPTH = tbped_pkg::QUEUE_DEPTH;

  tbped_pkg::evt_list_t mem_r [DEPTH];
  logic [tbped_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [tbped_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  function automatic logic [tbped_pkg::QPTR_W-1:0] bump(
    input logic [tbped_pkg::QPTR_W-1:0] p);
    bump = (p == tbped_pkg::QPTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (cnt_r != tbped_pkg::QCNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_list   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? bump(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + tbped_pkg::QCNT_W'(do_push) - tbped_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.list;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tbped_pkg::QCNT_W'(DEPTH))
    else $error("event queue overfilled");

endmodule

@@ src/tbped_back.sv @@
// Back end: play out each queued event list one event per transaction.
module tbped_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  list_valid,
  input  tbped_pkg::evt_list_t  list,
  output logic                  list_pop,
  tbped_out_if.source           out_ch
);

  logic [tbped_pkg::EV_IDX_W-1:0] pos_r, pos_nxt;
  logic is_last, fire;

  assign is_last = ({1'b0, pos_r} == list.count - 1'b1);
  assign fire    = out_ch.valid && out_ch.ready;

  assign out_ch.valid      = list_valid;
  assign out_ch.event_code = list.codes[pos_r];
  assign out_ch.last_event = is_last;
  assign list_pop          = fire && is_last;

  always_comb begin
    pos_nxt = pos_r;
    if (fire) begin
      pos_nxt = is_last ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  a_pos_inside: assert property (@(posedge clk) disable iff (!rst_n)
    list_valid |-> ({1'b0, pos_r} < list.count))
    else $error("event index beyond list");

endmodule

@@ src/two_button_press_event_detector.sv @@
// Top level: two-button press event detector with debounced press, release and repeats.
// Path: an accepted scan's event list is registered in the queue and is played out from its head.
// Throughput: one event per cycle while the receiver is ready; a scan yields 0 to 4
//   events, and the front end takes a new scan every cycle while the two-entry event
//   queue has room.
// Reset: synchronous, active low; clears held flags, stamps, repeat counter and
//   queue, and loads the hold times 3 s (single) and 2 s (combined).
module two_button_press_event_detector #(
  parameter int REPEAT_DIVIDE = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tbped_in_if.sink                         in_ch,
  tbped_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [tbped_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbped_pkg::HOLD_W-1:0]     cfg_data
);

  // Hold-time registers; the user must write them only while idle; the block does not enforce it.
  logic [tbped_pkg::HOLD_W-1:0] long_hold_r, long_hold_nxt;
  logic [tbped_pkg::HOLD_W-1:0] combo_hold_r, combo_hold_nxt;

  tbped_pkg::evt_push_t push;
  logic                 push_ready;
  logic                 list_valid;
  tbped_pkg::evt_list_t head_list;
  logic                 list_pop;

  always_comb begin
    long_hold_nxt  = long_hold_r;
    combo_hold_nxt = combo_hold_r;
    if (cfg_we) begin
      case (tbped_pkg::cfg_index_t'(cfg_index))
        tbped_pkg::CFG_LONG_HOLD:  long_hold_nxt  = cfg_data;
        tbped_pkg::CFG_COMBO_HOLD: combo_hold_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_hold_r  <= tbped_pkg::LONG_HOLD_RST;
      combo_hold_r <= tbped_pkg::COMBO_HOLD_RST;
    end else begin
      long_hold_r  <= long_hold_nxt;
      combo_hold_r <= combo_hold_nxt;
    end
  end

  // Classify each scan combinationally; the button state advances on the transaction.
  tbped_front #(
    .REPEAT_DIVIDE (REPEAT_DIVIDE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .scan_valid   (in_ch.valid),
    .scan_ready   (in_ch.ready),
    .set_level    (in_ch.set_level),
    .set_confirm  (in_ch.set_confirm),
    .mode_level   (in_ch.mode_level),
    .mode_confirm (in_ch.mode_confirm),
    .now_seconds  (in_ch.now_seconds),
    .long_hold    (long_hold_r),
    .combo_hold   (combo_hold_r),
    .push         (push),
    .push_ready   (push_ready)
  );

  // Hold finished event lists so the front end keeps scanning while output stalls, until full.
  tbped_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (list_valid),
    .pop_list   (head_list),
    .pop        (list_pop)
  );

  // Drain the head list, marking its final event.
  tbped_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .list_valid (list_valid),
    .list       (head_list),
    .list_pop   (list_pop),
    .out_ch     (out_ch)
  );

  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_event |=> out_ch.valid)
    else $error("event list cut short");

endmodule

@@ tb/sv/tb_two_button_press_event_detector.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the two-button press event detector.

module tb_two_button_press_event_detector;

  localparam int REPEAT_DIVIDE = 8;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 65;

  // Tracks button state, predicts the events of each scan and checks what comes out.
  class press_event_scoreboard;
    typedef struct {
      tbped_pkg::event_code_t code;
      bit                     last;
    } event_rec_t;

    event_rec_t             awaited_events[$];
    tbped_pkg::event_code_t scan_events[$];

    bit          held[2];
    bit [31:0]   stamp[2];
    int unsigned repeat_cnt;
    bit [7:0]    long_hold;
    bit [7:0]    combo_hold;

    int failures;
    int scans;
    int events_checked;
    int code_hits[10];

    function new();
      long_hold  = tbped_pkg::LONG_HOLD_RST;
      combo_hold = tbped_pkg::COMBO_HOLD_RST;
      held       = '{0, 0};
      stamp      = '{0, 0};
      repeat_cnt = 0;
    endfunction

    function void write_reg(tbped_pkg::cfg_index_t idx, bit [7:0] val);
      case (idx)
        tbped_pkg::CFG_LONG_HOLD:  long_hold  = val;
        tbped_pkg::CFG_COMBO_HOLD: combo_hold = val;
        default: ;
      endcase
    endfunction

    function void add_event(tbped_pkg::event_code_t code);
      if (scan_events.size() < tbped_pkg::MAX_EVENTS) scan_events.push_back(code);
    endfunction

    function bit repeat_due();
      repeat_cnt = (repeat_cnt + 1) % REPEAT_DIVIDE;
      return repeat_cnt == 0;
    endfunction

    function void step_button(int b, bit lvl, bit cnf, bit [31:0] now, bit other_held,
                              tbped_pkg::event_code_t dn, tbped_pkg::event_code_t up,
                              tbped_pkg::event_code_t prs, tbped_pkg::event_code_t lng);
      bit [31:0] elapsed;
      elapsed = now - stamp[b];
      if (lvl && !held[b]) begin
        if (cnf) begin
          add_event(dn);
          held[b]    = 1'b1;
          repeat_cnt = 0;
          stamp[b]   = now;
        end
      end else if (lvl && held[b]) begin
        if (elapsed >= {24'd0, long_hold} && repeat_due()) add_event(lng);
      end else if (!lvl && held[b]) begin
        add_event(up);
        held[b] = 1'b0;
        if (elapsed < {24'd0, long_hold}) begin
          add_event(prs);
          if (other_held) add_event(tbped_pkg::EV_BOTH_PRESS);
        end
      end
    endfunction

    // Work out the events of one accepted scan and queue them.
    function void note_scan(bit s_lvl, bit s_cnf, bit m_lvl, bit m_cnf, bit [31:0] now);
      bit [31:0] set_age;
      bit [31:0] mode_age;
      event_rec_t rec;
      scan_events.delete();
      step_button(0, s_lvl, s_cnf, now, held[1],
                  tbped_pkg::EV_SET_DOWN, tbped_pkg::EV_SET_UP,
                  tbped_pkg::EV_SET_PRESS, tbped_pkg::EV_SET_LONG);
      step_button(1, m_lvl, m_cnf, now, held[0],
                  tbped_pkg::EV_MODE_DOWN, tbped_pkg::EV_MODE_UP,
                  tbped_pkg::EV_MODE_PRESS, tbped_pkg::EV_MODE_LONG);
      set_age  = now - stamp[0];
      mode_age = now - stamp[1];
      if (s_lvl && held[0] && m_lvl && held[1] &&
          mode_age >= {24'd0, combo_hold} && set_age >= {24'd0, combo_hold}) begin
        if (repeat_due()) add_event(tbped_pkg::EV_BOTH_LONG);
      end
      foreach (scan_events[i]) begin
        rec.code = scan_events[i];
        rec.last = (i == scan_events.size() - 1);
        awaited_events.push_back(rec);
      end
      scans++;
    endfunction

    function void check_event(logic [3:0] code, logic last);
      event_rec_t want;
      if (awaited_events.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] unexpected event: code=%0d last=%0b", $realtime, code, last);
        return;
      end
      want = awaited_events.pop_front();
      events_checked++;
      if (code !== want.code || last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] event mismatch: expected %s last=%0b, got code=%0d last=%0b",
                   $realtime, want.code.name(), want.last, code, last);
      end else begin
        code_hits[want.code]++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tbped_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tbped_pkg::HOLD_W-1:0]    cfg_data;

  tbped_in_if  scan_ch ();
  tbped_out_if event_ch ();

  press_event_scoreboard sb = new();

  // Idling enables: sender gaps and receiver stalls.
  bit sender_idle;
  bit sink_idle;
  int stall_left;

  // Seconds timeline of the random part.
  bit [31:0] clock_s;

  two_button_press_event_detector #(
    .REPEAT_DIVIDE(REPEAT_DIVIDE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (scan_ch),
    .out_ch    (event_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: stall in random bursts while stalling is enabled.
  always @(posedge clk) begin
    if (stall_left > 0)
      stall_left--;
    else if (sink_idle && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 15);
    event_ch.ready <= (stall_left == 0);
  end

  // Check every event transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && event_ch.valid && event_ch.ready)
      sb.check_event(event_ch.event_code, event_ch.last_event);
  end

  // Offer one scan, optionally after a gap, and hold it until the transaction completes.
  task automatic send_scan(bit s_lvl, bit s_cnf, bit m_lvl, bit m_cnf, bit [31:0] now);
    int gap;
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      scan_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_ch.valid        <= 1'b1;
    scan_ch.set_level    <= s_lvl;
    scan_ch.set_confirm  <= s_cnf;
    scan_ch.mode_level   <= m_lvl;
    scan_ch.mode_confirm <= m_cnf;
    scan_ch.now_seconds  <= now;
    @(posedge clk);
    while (!scan_ch.ready) @(posedge clk);
    sb.note_scan(s_lvl, s_cnf, m_lvl, m_cnf, now);
  endtask

  // Drop valid so that the last scan is not taken twice.
  task automatic pause_sender();
    scan_ch.valid <= 1'b0;
  endtask

  // Wait for every predicted event, then let the bench idle.
  task automatic wait_drained();
    while (sb.awaited_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the long hold time, then the combined hold time; only call while idle.
  task automatic set_holds(bit [7:0] long_s, bit [7:0] combo_s);
    cfg_we    <= 1'b1;
    cfg_index <= tbped_pkg::CFG_LONG_HOLD;
    cfg_data  <= long_s;
    @(posedge clk);
    sb.write_reg(tbped_pkg::CFG_LONG_HOLD, long_s);
    cfg_index <= tbped_pkg::CFG_COMBO_HOLD;
    cfg_data  <= combo_s;
    @(posedge clk);
    sb.write_reg(tbped_pkg::CFG_COMBO_HOLD, combo_s);
    cfg_we <= 1'b0;
  endtask

  // Directed scans at the reset hold times (3 s single, 2 s combined).
  task automatic run_directed();
    // quiet scan, then a set level that the debounce sample does not confirm
    send_scan(0, 0, 0, 0, 32'd0);
    send_scan(1, 0, 0, 0, 32'd0);
    // set down; then mode down while the set confirmation is ignored
    send_scan(1, 1, 0, 0, 32'd0);
    send_scan(1, 0, 1, 1, 32'd1);
    // short set release with mode still held: up, press, combined press
    send_scan(0, 1, 1, 0, 32'd1);
    send_scan(0, 0, 0, 0, 32'd2);
    // both down together, then hold past both thresholds so repeats share the counter
    send_scan(1, 1, 1, 1, 32'd10);
    for (int i = 0; i < 6; i++)
      send_scan(1, 0, 1, 0, 32'd13 + i);
    // long release of both: ups only
    send_scan(0, 0, 0, 0, 32'd20);
    // short release of both in one scan: fifth event is dropped
    send_scan(1, 1, 1, 1, 32'd30);
    send_scan(0, 0, 0, 0, 32'd31);
    // hold across the counter wrap
    send_scan(1, 1, 0, 0, 32'hFFFF_FFFE);
    send_scan(1, 0, 0, 1, 32'hFFFF_FFFF);
    send_scan(1, 0, 0, 0, 32'd1);
    send_scan(0, 0, 0, 0, 32'd2);
    // mode alone, all-ones timestamp, released at zero
    send_scan(0, 0, 1, 1, 32'hFFFF_FFFF);
    send_scan(0, 0, 0, 0, 32'd0);
  endtask

  // Random phase: mostly realistic press/hold/release runs, some noise scans.
  task automatic run_phase(int items, int pause_at);
    bit        want_down[2];
    int        run_left[2];
    bit        lvl[2];
    bit        cnf[2];
    bit [31:0] now;
    want_down = '{0, 0};
    run_left  = '{0, 0};
    for (int n = 0; n < items; n++) begin
      if (n == pause_at) begin
        pause_sender();
        wait_drained();
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: any levels, any confirmation, a jump anywhere on the timeline
        for (int b = 0; b < 2; b++) begin
          lvl[b] = 1'($urandom_range(0, 1));
          cnf[b] = 1'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 1)) clock_s = $urandom();
        now = clock_s;
      end else begin
        for (int b = 0; b < 2; b++) begin
          if (run_left[b] == 0) begin
            want_down[b] = !want_down[b];
            run_left[b]  = want_down[b] ? $urandom_range(1, 40) : $urandom_range(1, 6);
          end
          run_left[b]--;
          lvl[b] = want_down[b];
          // an occasional unconfirmed press mimics contact bounce
          cnf[b] = lvl[b] ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1));
        end
        case ($urandom_range(0, 5))
          0, 1:    clock_s = clock_s;
          2, 3, 4: clock_s = clock_s + 1;
          default: clock_s = clock_s + $urandom_range(2, 300);
        endcase
        now = clock_s;
      end
      send_scan(lvl[0], cnf[0], lvl[1], cnf[1], now);
    end
    pause_sender();
  endtask

  initial begin
    bit [7:0] long_set[PHASES];
    bit [7:0] combo_set[PHASES];

    long_set  = '{8'd0, 8'd255, 8'd3, 8'd0,   8'd1, 8'd0, 8'd2};
    combo_set = '{8'd0, 8'd255, 8'd2, 8'd255, 8'd4, 8'd0, 8'd1};
    long_set[5]  = 8'($urandom_range(0, 255));
    combo_set[5] = 8'($urandom_range(0, 8));

    // Hold every input at a known value while reset is held low.
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = tbped_pkg::CFG_LONG_HOLD;
    cfg_data             = '0;
    scan_ch.valid        = 1'b0;
    scan_ch.set_level    = 1'b0;
    scan_ch.set_confirm  = 1'b0;
    scan_ch.mode_level   = 1'b0;
    scan_ch.mode_confirm = 1'b0;
    scan_ch.now_seconds  = '0;
    event_ch.ready       = 1'b0;
    stall_left           = 0;
    sender_idle          = 1'b1;
    sink_idle            = 1'b1;
    clock_s              = $urandom();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    pause_sender();
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      // no idling in the last phase, and none in phase 2 either
      sender_idle = (p != PHASES - 1) && (p != 2);
      sink_idle   = sender_idle;
      set_holds(long_set[p], combo_set[p]);
      run_phase(PHASE_ITEMS, (p == 1) ? PHASE_ITEMS / 2 : -1);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d scans and %0d events over %0d hold-time settings:",
             sb.scans, sb.events_checked, PHASES + 1);
    $display("  %0d single long repeats, %0d combined long, %0d combined press",
             sb.code_hits[tbped_pkg::EV_SET_LONG] + sb.code_hits[tbped_pkg::EV_MODE_LONG],
             sb.code_hits[tbped_pkg::EV_BOTH_LONG], sb.code_hits[tbped_pkg::EV_BOTH_PRESS]);
    if (sb.failures == 0 && sb.awaited_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10_000_000;
    $display("Timed out with %0d events still awaited", sb.awaited_events.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
